// ----- src/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, constants, codes and helpers for the mixer / arming / ramp
// block and its digit-serial multiplier.
// ----------------------------------------------------------------------------
package rcm_pkg;

	// field widths
	localparam int CH_W    = 11;
	localparam int GAIN_W  = 16;
	localparam int CNT_W   = 16;
	localparam int DRV_W   = 16;
	localparam int FAC_W   = 17;
	localparam int IDX_W   = 4;
	localparam int DATA_W  = 16;

	// serial multiplier geometry: signed multiplicand, unsigned multiplier
	localparam int MCAND_W  = 17;
	localparam int MPLIER_W = 18;
	localparam int DIGIT_W  = 2;
	localparam int PROD_W   = MCAND_W + MPLIER_W;
	localparam int STEPS    = MPLIER_W / DIGIT_W;
	localparam int STEP_W   = $clog2(STEPS + 1);

	// mixing arithmetic
	localparam int DIFF_W  = CH_W + 1;
	localparam int SUM_W   = 21;
	localparam int MIX_SH  = 8;
	localparam int SCL_SH  = 16;

	// ramp constants
	localparam logic [FAC_W-1:0] Q_ONE      = FAC_W'(65536);
	localparam logic [FAC_W-1:0] FACTOR_MAX = FAC_W'(131071);
	localparam logic [FAC_W-1:0] RAMP_STEP  = FAC_W'(66);

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_THROTTLE_ZERO = 4'd0,
		REG_THROTTLE_GAIN = 4'd1,
		REG_TURN_CENTER   = 4'd2,
		REG_TURN_GAIN     = 4'd3,
		REG_DEADBAND_LOW  = 4'd4,
		REG_DEADBAND_HIGH = 4'd5,
		REG_ARM_THRESHOLD = 4'd6,
		REG_LOSS_LIMIT    = 4'd7
	} reg_idx_t;

	// how the final drives are formed
	typedef enum logic [1:0] {
		DRV_ZERO,
		DRV_PASS,
		DRV_SCALE
	} drv_mode_t;

	// saturate a wide signed sum to a Q1.15 drive
	function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32767);
		lo = -SUM_W'(32768);
		if (v > hi) begin
			return DRV_W'(32767);
		end else if (v < lo) begin
			return DRV_W'(-32768);
		end
		return v[DRV_W-1:0];
	endfunction

endpackage

// ----- src/rcm_ser_mul.sv -----
// ----------------------------------------------------------------------------
// rcm_ser_mul
// Digit-serial multiplier: signed multiplicand times unsigned multiplier,
// two multiplier bits retired per cycle by shift-and-add.
// ----------------------------------------------------------------------------
module rcm_ser_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rcm_pkg::MCAND_W-1:0]  mcand,
	input  logic        [rcm_pkg::MPLIER_W-1:0] mplier,
	output logic                                done,
	output logic signed [rcm_pkg::PROD_W-1:0]   product
);

	logic        [rcm_pkg::STEP_W-1:0]   cnt_q;
	logic                                done_q;
	logic signed [rcm_pkg::PROD_W-1:0]   mc_q;
	logic signed [rcm_pkg::PROD_W-1:0]   mc3_q;
	logic        [rcm_pkg::MPLIER_W-1:0] mp_q;
	logic signed [rcm_pkg::PROD_W-1:0]   acc_q;
	logic signed [rcm_pkg::PROD_W-1:0]   mc_ext;
	logic signed [rcm_pkg::PROD_W-1:0]   pp;

	// sign-extended multiplicand
	assign mc_ext = {{(rcm_pkg::PROD_W - rcm_pkg::MCAND_W){mcand[rcm_pkg::MCAND_W-1]}}, mcand};

	// partial product for the current digit
	always_comb begin
		unique case (mp_q[rcm_pkg::DIGIT_W-1:0])
			2'd0: pp = '0;
			2'd1: pp = mc_q;
			2'd2: pp = mc_q <<< 1;
			2'd3: pp = mc3_q;
			default: pp = '0;
		endcase
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= rcm_pkg::STEP_W'(rcm_pkg::STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == rcm_pkg::STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift registers and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= mc_ext;
			mc3_q <= mc_ext + (mc_ext <<< 1);
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			mc_q  <= mc_q <<< rcm_pkg::DIGIT_W;
			mc3_q <= mc3_q <<< rcm_pkg::DIGIT_W;
			mp_q  <= mp_q >> rcm_pkg::DIGIT_W;
			acc_q <= acc_q + pp;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- src/rc_mix_arm_ramp_unit.sv -----
// ----------------------------------------------------------------------------
// rc_mix_arm_ramp_unit
// Per-tick radio frame hold, link-loss count, throttle/turn mixing with
// deadband, arming and soft arm/disarm drive ramp.
// ----------------------------------------------------------------------------
// One input word is one tick. The block takes a word only when its sequencer
// is idle and returns exactly one result word per tick. The sequencer returns
// to idle as the result word is registered, so the next word can be taken in
// the same cycle that the result is presented. Two digit-serial multipliers
// work side by side, each pass a start, 9 two-bit steps and a done check:
// first for the turn and throttle gains, then, while a ramp is scaling the
// drives, again for the ramp factor on left and right. The output register
// lets the next word be taken while a result still waits.
// Configuration writes are always ready; write them only while the block is
// idle. Indexes beyond the eight registers are ignored.
module rc_mix_arm_ramp_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [rcm_pkg::IDX_W-1:0]      cfg_index,
	input  logic        [rcm_pkg::DATA_W-1:0]     cfg_data,
	// tick input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  frame_valid,
	input  logic        [rcm_pkg::CH_W-1:0]       throttle_ch,
	input  logic        [rcm_pkg::CH_W-1:0]       turn_channel,
	input  logic        [rcm_pkg::CH_W-1:0]       arm_channel,
	// result
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rcm_pkg::DRV_W-1:0]      left_drive,
	output logic signed [rcm_pkg::DRV_W-1:0]      right_drive,
	output logic                                  is_armed,
	output logic                                  link_lost
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL1,
		ST_MIX,
		ST_RAMP,
		ST_MUL2,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [rcm_pkg::CH_W-1:0]   throttle_zero_q;
	logic [rcm_pkg::GAIN_W-1:0] throttle_gain_q;
	logic [rcm_pkg::CH_W-1:0]   turn_center_q;
	logic [rcm_pkg::GAIN_W-1:0] turn_gain_q;
	logic [rcm_pkg::CH_W-1:0]   deadband_low_q;
	logic [rcm_pkg::CH_W-1:0]   deadband_high_q;
	logic [rcm_pkg::CH_W-1:0]   arm_threshold_q;
	logic [rcm_pkg::CNT_W-1:0]  loss_limit_q;

	// tick state
	logic [rcm_pkg::CH_W-1:0]   held_throttle_q;
	logic [rcm_pkg::CH_W-1:0]   held_turn_q;
	logic [rcm_pkg::CH_W-1:0]   held_arm_q;
	logic [rcm_pkg::CNT_W-1:0]  missing_q;
	logic                       was_armed_q;
	logic                       ramping_up_q;
	logic                       ramping_down_q;
	logic [rcm_pkg::FAC_W-1:0]  ramp_factor_q;

	// per-tick working registers
	logic                       armed_q;
	logic                       lost_q;
	logic signed [rcm_pkg::DRV_W-1:0] drv_l_q;
	logic signed [rcm_pkg::DRV_W-1:0] drv_r_q;
	logic [rcm_pkg::FAC_W-1:0]  fac_use_q;
	rcm_pkg::drv_mode_t         mode_q;

	// result register
	logic                       out_valid_q;
	logic signed [rcm_pkg::DRV_W-1:0] left_q;
	logic signed [rcm_pkg::DRV_W-1:0] right_q;
	logic                       is_armed_q;
	logic                       link_lost_q;

	// multiplier lanes
	logic                              start_a;
	logic                              start_b;
	logic signed [rcm_pkg::MCAND_W-1:0]  mcand_a;
	logic signed [rcm_pkg::MCAND_W-1:0]  mcand_b;
	logic        [rcm_pkg::MPLIER_W-1:0] mplier_a;
	logic        [rcm_pkg::MPLIER_W-1:0] mplier_b;
	logic                              done_a;
	logic                              done_b;
	logic signed [rcm_pkg::PROD_W-1:0] prod_a;
	logic signed [rcm_pkg::PROD_W-1:0] prod_b;

	// combinational helpers
	logic signed [rcm_pkg::DIFF_W-1:0] turn_diff;
	logic signed [rcm_pkg::DIFF_W-1:0] thr_diff;
	logic                              lost_now;
	logic                              armed_now;
	logic signed [rcm_pkg::SUM_W-1:0]  trn_term;
	logic signed [rcm_pkg::SUM_W-1:0]  thr_term;
	logic                              turn_right;
	logic                              turn_left;
	logic signed [rcm_pkg::SUM_W-1:0]  left_sum;
	logic signed [rcm_pkg::SUM_W-1:0]  right_sum;
	logic [rcm_pkg::FAC_W:0]           fac_up;
	logic [rcm_pkg::FAC_W-1:0]         fac_up_sat;
	logic [rcm_pkg::FAC_W-1:0]         fac_down;
	logic signed [rcm_pkg::SUM_W-1:0]  scl_l;
	logic signed [rcm_pkg::SUM_W-1:0]  scl_r;
	logic signed [rcm_pkg::DRV_W-1:0]  fin_l;
	logic signed [rcm_pkg::DRV_W-1:0]  fin_r;
	logic                              out_free;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_zero_q <= rcm_pkg::CH_W'(174);
			throttle_gain_q <= rcm_pkg::GAIN_W'(1537);
			turn_center_q   <= rcm_pkg::CH_W'(992);
			turn_gain_q     <= rcm_pkg::GAIN_W'(1024);
			deadband_low_q  <= rcm_pkg::CH_W'(990);
			deadband_high_q <= rcm_pkg::CH_W'(994);
			arm_threshold_q <= rcm_pkg::CH_W'(900);
			loss_limit_q    <= rcm_pkg::CNT_W'(100);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rcm_pkg::REG_THROTTLE_ZERO: throttle_zero_q <= cfg_data[rcm_pkg::CH_W-1:0];
				rcm_pkg::REG_THROTTLE_GAIN: throttle_gain_q <= cfg_data[rcm_pkg::GAIN_W-1:0];
				rcm_pkg::REG_TURN_CENTER:   turn_center_q   <= cfg_data[rcm_pkg::CH_W-1:0];
				rcm_pkg::REG_TURN_GAIN:     turn_gain_q     <= cfg_data[rcm_pkg::GAIN_W-1:0];
				rcm_pkg::REG_DEADBAND_LOW:  deadband_low_q  <= cfg_data[rcm_pkg::CH_W-1:0];
				rcm_pkg::REG_DEADBAND_HIGH: deadband_high_q <= cfg_data[rcm_pkg::CH_W-1:0];
				rcm_pkg::REG_ARM_THRESHOLD: arm_threshold_q <= cfg_data[rcm_pkg::CH_W-1:0];
				rcm_pkg::REG_LOSS_LIMIT:    loss_limit_q    <= cfg_data[rcm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// channel offsets and arming decision
	assign turn_diff = $signed({1'b0, held_turn_q}) - $signed({1'b0, turn_center_q});
	assign thr_diff  = $signed({1'b0, held_throttle_q}) - $signed({1'b0, throttle_zero_q});
	assign lost_now  = missing_q > loss_limit_q;
	assign armed_now = (held_arm_q >= arm_threshold_q) && !lost_now;

	// operand selection for the two lanes
	assign start_a = (state_q == ST_LOAD) || ((state_q == ST_RAMP) && (mode_q == rcm_pkg::DRV_SCALE));
	assign start_b = start_a;

	always_comb begin
		if (state_q == ST_LOAD) begin
			mcand_a  = {{(rcm_pkg::MCAND_W - rcm_pkg::DIFF_W){turn_diff[rcm_pkg::DIFF_W-1]}},
				turn_diff};
			mcand_b  = {{(rcm_pkg::MCAND_W - rcm_pkg::DIFF_W){thr_diff[rcm_pkg::DIFF_W-1]}},
				thr_diff};
			mplier_a = rcm_pkg::MPLIER_W'(turn_gain_q);
			mplier_b = rcm_pkg::MPLIER_W'(throttle_gain_q);
		end else begin
			mcand_a  = rcm_pkg::MCAND_W'(drv_l_q);
			mcand_b  = rcm_pkg::MCAND_W'(drv_r_q);
			mplier_a = rcm_pkg::MPLIER_W'(fac_use_q);
			mplier_b = rcm_pkg::MPLIER_W'(fac_use_q);
		end
	end

	rcm_ser_mul u_mul_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.mcand   (mcand_a),
		.mplier  (mplier_a),
		.done    (done_a),
		.product (prod_a)
	);

	rcm_ser_mul u_mul_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_b),
		.mcand   (mcand_b),
		.mplier  (mplier_b),
		.done    (done_b),
		.product (prod_b)
	);

	// mixing: gain terms floored by the Q8 shift, deadband, saturation
	assign trn_term   = prod_a[rcm_pkg::MIX_SH+rcm_pkg::SUM_W-1:rcm_pkg::MIX_SH];
	assign thr_term   = prod_b[rcm_pkg::MIX_SH+rcm_pkg::SUM_W-1:rcm_pkg::MIX_SH];
	assign turn_right = held_turn_q > deadband_high_q;
	assign turn_left  = !turn_right && (held_turn_q < deadband_low_q);
	assign left_sum   = thr_term + (turn_right ? trn_term : '0);
	assign right_sum  = thr_term - (turn_left ? trn_term : '0);

	// ramp factor steps
	assign fac_up     = {1'b0, ramp_factor_q} + {1'b0, rcm_pkg::RAMP_STEP};
	assign fac_up_sat = (fac_up > {1'b0, rcm_pkg::FACTOR_MAX}) ? rcm_pkg::FACTOR_MAX
		: fac_up[rcm_pkg::FAC_W-1:0];
	assign fac_down   = (ramp_factor_q > rcm_pkg::RAMP_STEP) ? (ramp_factor_q - rcm_pkg::RAMP_STEP)
		: '0;

	// scaled drives floored by the Q1.16 shift
	assign scl_l = {{(rcm_pkg::SUM_W - (rcm_pkg::PROD_W - rcm_pkg::SCL_SH)){prod_a[rcm_pkg::PROD_W-1]}},
		prod_a[rcm_pkg::PROD_W-1:rcm_pkg::SCL_SH]};
	assign scl_r = {{(rcm_pkg::SUM_W - (rcm_pkg::PROD_W - rcm_pkg::SCL_SH)){prod_b[rcm_pkg::PROD_W-1]}},
		prod_b[rcm_pkg::PROD_W-1:rcm_pkg::SCL_SH]};

	// final drive selection
	always_comb begin
		unique case (mode_q)
			rcm_pkg::DRV_PASS: begin
				fin_l = drv_l_q;
				fin_r = drv_r_q;
			end
			rcm_pkg::DRV_SCALE: begin
				fin_l = rcm_pkg::sat_drive(scl_l);
				fin_r = rcm_pkg::sat_drive(scl_r);
			end
			default: begin
				fin_l = '0;
				fin_r = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	// sequencer, tick state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			held_throttle_q <= '0;
			held_turn_q     <= '0;
			held_arm_q      <= '0;
			missing_q       <= '0;
			was_armed_q     <= 1'b0;
			ramping_up_q    <= 1'b0;
			ramping_down_q  <= 1'b0;
			ramp_factor_q   <= '0;
			armed_q         <= 1'b0;
			lost_q          <= 1'b0;
			drv_l_q         <= '0;
			drv_r_q         <= '0;
			fac_use_q       <= '0;
			mode_q          <= rcm_pkg::DRV_ZERO;
			out_valid_q     <= 1'b0;
			left_q          <= '0;
			right_q         <= '0;
			is_armed_q      <= 1'b0;
			link_lost_q     <= 1'b0;
		end else begin
			// result word leaves, unless a new one is loaded in its place
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (frame_valid) begin
							missing_q       <= '0;
							held_throttle_q <= throttle_ch;
							held_turn_q     <= turn_channel;
							held_arm_q      <= arm_channel;
						end else if (missing_q != '1) begin
							missing_q <= missing_q + 1'b1;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					armed_q <= armed_now;
					lost_q  <= lost_now;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					if (done_a && done_b) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					drv_l_q   <= rcm_pkg::sat_drive(left_sum);
					drv_r_q   <= rcm_pkg::sat_drive(right_sum);
					fac_use_q <= ramp_factor_q;
					if (armed_q && !was_armed_q) begin
						ramping_up_q  <= 1'b1;
						ramp_factor_q <= '0;
						mode_q        <= rcm_pkg::DRV_ZERO;
					end else if (armed_q) begin
						if (ramping_up_q && (ramp_factor_q < rcm_pkg::Q_ONE)) begin
							ramp_factor_q <= fac_up_sat;
							mode_q        <= rcm_pkg::DRV_SCALE;
						end else if (ramping_up_q) begin
							ramping_up_q  <= 1'b0;
							ramp_factor_q <= '0;
							mode_q        <= rcm_pkg::DRV_PASS;
						end else begin
							mode_q <= rcm_pkg::DRV_PASS;
						end
					end else if (was_armed_q) begin
						ramping_down_q <= 1'b1;
						ramp_factor_q  <= rcm_pkg::Q_ONE;
						mode_q         <= rcm_pkg::DRV_PASS;
					end else if (ramping_down_q && (ramp_factor_q != '0)) begin
						ramp_factor_q <= fac_down;
						mode_q        <= rcm_pkg::DRV_SCALE;
					end else if (ramping_down_q) begin
						ramping_down_q <= 1'b0;
						ramp_factor_q  <= '0;
						mode_q         <= rcm_pkg::DRV_ZERO;
					end else begin
						mode_q <= rcm_pkg::DRV_ZERO;
					end
					was_armed_q <= armed_q;
					state_q     <= ST_RAMP;
				end
				ST_RAMP: begin
					state_q <= (mode_q == rcm_pkg::DRV_SCALE) ? ST_MUL2 : ST_FIN;
				end
				ST_MUL2: begin
					if (done_a && done_b) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						left_q      <= fin_l;
						right_q     <= fin_r;
						is_armed_q  <= armed_q;
						link_lost_q <= lost_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ports
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign is_armed    = is_armed_q;
	assign link_lost   = link_lost_q;

endmodule

// ----- src/rcm_checker.sv -----
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks on the mixer / arming / ramp block, bound to its top level.
// ----------------------------------------------------------------------------
module rcm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [rcm_pkg::DRV_W-1:0]  left_drive,
	input logic signed [rcm_pkg::DRV_W-1:0]  right_drive,
	input logic                              is_armed,
	input logic                              link_lost
);

	// a waiting result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive) && $stable(right_drive))
		else $error("result word changed while stalled");

	// one word at a time through the sequencer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in progress");

	// a lost link never reports armed
	a_lost_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && link_lost |-> !is_armed)
		else $error("armed while link lost");

	// the tick that enters arming drives nothing
	a_arm_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $rose(is_armed) |-> (left_drive == '0) && (right_drive == '0))
		else $error("non-zero drive on arming tick");

endmodule

bind rc_mix_arm_ramp_unit rcm_checker u_rcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.is_armed    (is_armed),
	.link_lost   (link_lost)
);

// ----- sim/rc_mix_arm_ramp_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_mix_arm_ramp_unit_test
// Self-checking bench for the tick mixer: a local predictor of hold, loss
// count, mixing, arming and ramp follows every accepted tick word, and each
// result word is compared field by field. Directed corner ticks come first,
// then a long randomised ramp-up, register sweeps, an output stall and a
// frame-less run that loses the link and ramps the drives down.
// ----------------------------------------------------------------------------
module rc_mix_arm_ramp_unit_test;
	import rcm_pkg::*;

	localparam int CH_MAX        = (1 << CH_W) - 1;
	localparam int UNITY         = 65536;
	localparam int RISE_STEP     = 66;
	localparam int FACTOR_CEIL   = 131071;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int MISS_RUN      = 350;
	localparam int REPORT_MAX    = 10;
	localparam logic [IDX_W-1:0] IDX_SPARE_LOW = 4'd8;
	localparam logic [IDX_W-1:0] IDX_SPARE_TOP = 4'd15;

	typedef struct {
		logic            frame;
		logic [CH_W-1:0] throttle;
		logic [CH_W-1:0] turn;
		logic [CH_W-1:0] arm;
	} tick_t;

	typedef struct {
		logic signed [DRV_W-1:0] left;
		logic signed [DRV_W-1:0] right;
		logic                    armed;
		logic                    lost;
	} drive_word_t;

	typedef enum {ARM_UP, ARM_DOWN, ARM_ANY} arm_pick_t;

	// dut connections
	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [IDX_W-1:0]        cfg_index;
	logic [DATA_W-1:0]       cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    frame_valid;
	logic [CH_W-1:0]         throttle_ch;
	logic [CH_W-1:0]         turn_channel;
	logic [CH_W-1:0]         arm_channel;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [DRV_W-1:0] left_drive;
	logic signed [DRV_W-1:0] right_drive;
	logic                    is_armed;
	logic                    link_lost;

	// predictor registers, reset values
	logic [CH_W-1:0]  zero_thr    = 11'd174;
	logic [GAIN_W-1:0] gain_thr   = 16'd1537;
	logic [CH_W-1:0]  centre_turn = 11'd992;
	logic [GAIN_W-1:0] gain_turn  = 16'd1024;
	logic [CH_W-1:0]  band_lo     = 11'd990;
	logic [CH_W-1:0]  band_hi     = 11'd994;
	logic [CH_W-1:0]  arm_level   = 11'd900;
	logic [CNT_W-1:0] loss_max    = 16'd100;

	// predictor state
	logic [CH_W-1:0]  hold_thr   = '0;
	logic [CH_W-1:0]  hold_turn  = '0;
	logic [CH_W-1:0]  hold_arm   = '0;
	logic [CNT_W-1:0] dry_ticks  = '0;
	logic             armed_prev = 1'b0;
	logic             rising     = 1'b0;
	logic             falling    = 1'b0;
	longint           factor     = 0;

	drive_word_t pending_drives[$];
	int          fail_count = 0;
	int          words_seen = 0;
	bit          send_gaps  = 1'b1;
	bit          drain_gaps = 1'b1;
	int          hold_token = 0;

	rc_mix_arm_ramp_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.frame_valid      (frame_valid),
		.throttle_ch      (throttle_ch),
		.turn_channel     (turn_channel),
		.arm_channel      (arm_channel),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.left_drive       (left_drive),
		.right_drive      (right_drive),
		.is_armed         (is_armed),
		.link_lost        (link_lost)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic longint clip_q15(input longint v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	// drive times Q1.16 factor, floored
	function automatic longint ramp_scale(input longint d);
		return clip_q15((d * factor) >>> 16);
	endfunction

	function automatic drive_word_t mix_tick(input tick_t t);
		longint      l;
		longint      r;
		longint      trn;
		longint      thr;
		logic        armed;
		logic        lost;
		drive_word_t o;
		// frame hold and loss count
		if (t.frame) begin
			dry_ticks = '0;
			hold_thr  = t.throttle;
			hold_turn = t.turn;
			hold_arm  = t.arm;
		end else if (dry_ticks != '1) begin
			dry_ticks = dry_ticks + 1'b1;
		end
		// mixing with deadband
		trn = ((longint'(hold_turn) - longint'(centre_turn)) * longint'(gain_turn)) >>> 8;
		thr = ((longint'(hold_thr) - longint'(zero_thr)) * longint'(gain_thr)) >>> 8;
		l = 0;
		r = 0;
		if (hold_turn > band_hi) begin
			l = l + trn;
		end else if (hold_turn < band_lo) begin
			r = r - trn;
		end
		l = clip_q15(l + thr);
		r = clip_q15(r + thr);
		// arming
		lost  = dry_ticks > loss_max;
		armed = (hold_arm >= arm_level) && !lost;
		// ramp
		if (armed && !armed_prev) begin
			rising = 1'b1;
			factor = 0;
			l = 0;
			r = 0;
		end else if (armed) begin
			if (rising) begin
				if (factor < UNITY) begin
					l = ramp_scale(l);
					r = ramp_scale(r);
					factor = factor + RISE_STEP;
					if (factor > FACTOR_CEIL) factor = FACTOR_CEIL;
				end else begin
					rising = 1'b0;
					factor = 0;
				end
			end
		end else if (armed_prev) begin
			falling = 1'b1;
			factor  = UNITY;
		end else if (falling) begin
			if (factor > 0) begin
				l = ramp_scale(l);
				r = ramp_scale(r);
				factor = (factor > RISE_STEP) ? factor - RISE_STEP : 0;
			end else begin
				falling = 1'b0;
				factor  = 0;
				l = 0;
				r = 0;
			end
		end else begin
			l = 0;
			r = 0;
		end
		armed_prev = armed;
		o.left  = l[DRV_W-1:0];
		o.right = r[DRV_W-1:0];
		o.armed = armed;
		o.lost  = lost;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic tick_t make_tick(input logic frame, input int thr, input int trn,
			input int arm);
		tick_t t;
		t.frame    = frame;
		t.throttle = CH_W'(thr);
		t.turn     = CH_W'(trn);
		t.arm      = CH_W'(arm);
		return t;
	endfunction

	// channel value with extra weight on the ends of the range
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, CH_MAX));
		endcase
	endfunction

	function automatic tick_t pick_tick(input arm_pick_t mode, input int miss_pct);
		tick_t t;
		int    base;
		int    v;
		t.frame    = ($urandom_range(0, 99) >= miss_pct);
		t.throttle = pick_channel();
		// turn often lands on the deadband edges or the centre
		case ($urandom_range(0, 5))
			0: base = band_lo;
			1: base = band_hi;
			2: base = centre_turn;
			default: base = -1;
		endcase
		if (base < 0) begin
			t.turn = pick_channel();
		end else begin
			v = base + int'($urandom_range(0, 4)) - 2;
			if (v < 0) v = 0;
			if (v > CH_MAX) v = CH_MAX;
			t.turn = CH_W'(v);
		end
		case (mode)
			ARM_UP: begin
				if ($urandom_range(0, 3) == 0) t.arm = arm_level;
				else t.arm = CH_W'($urandom_range(arm_level, CH_MAX));
			end
			ARM_DOWN: begin
				if (arm_level == 0) t.arm = pick_channel();
				else if ($urandom_range(0, 3) == 0) t.arm = arm_level - 1'b1;
				else t.arm = CH_W'($urandom_range(0, arm_level - 1));
			end
			default: t.arm = pick_channel();
		endcase
		return t;
	endfunction

	// offer one tick word and record its expected result on acceptance
	task automatic send_tick(input tick_t t);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid         <= 1'b1;
		frame_valid      <= t.frame;
		throttle_ch      <= t.throttle;
		turn_channel     <= t.turn;
		arm_channel      <= t.arm;
		do @(posedge clk); while (!in_ready);
		pending_drives.push_back(mix_tick(t));
	endtask

	task automatic run_stretch(input int count, input arm_pick_t mode, input int miss_pct);
		repeat (count) send_tick(pick_tick(mode, miss_pct));
	endtask

	// stop offering and wait for every outstanding result word
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THROTTLE_ZERO: zero_thr    = val[CH_W-1:0];
			REG_THROTTLE_GAIN: gain_thr    = val;
			REG_TURN_CENTER:   centre_turn = val[CH_W-1:0];
			REG_TURN_GAIN:     gain_turn   = val;
			REG_DEADBAND_LOW:  band_lo     = val[CH_W-1:0];
			REG_DEADBAND_HIGH: band_hi     = val[CH_W-1:0];
			REG_ARM_THRESHOLD: arm_level   = val[CH_W-1:0];
			REG_LOSS_LIMIT:    loss_max    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_settings(input logic [DATA_W-1:0] tz, tg, tc, tn, dl, dh, at, ll);
		write_reg(REG_THROTTLE_ZERO, tz);
		write_reg(REG_THROTTLE_GAIN, tg);
		write_reg(REG_TURN_CENTER, tc);
		write_reg(REG_TURN_GAIN, tn);
		write_reg(REG_DEADBAND_LOW, dl);
		write_reg(REG_DEADBAND_HIGH, dh);
		write_reg(REG_ARM_THRESHOLD, at);
		write_reg(REG_LOSS_LIMIT, ll);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// channel extremes, deadband edges, arm entry and exit, link loss,
	// inverted deadband, writes to unused indexes
	task automatic test_directed_cases();
		write_reg(IDX_SPARE_LOW, 16'hFFFF);
		write_reg(IDX_SPARE_TOP, 16'h0000);
		send_tick(make_tick(1'b1, 2047, 0, 0));
		send_tick(make_tick(1'b0, 0, 0, 0));
		send_tick(make_tick(1'b1, 2047, 2047, 2047));
		send_tick(make_tick(1'b1, 2047, 2047, 2047));
		send_tick(make_tick(1'b1, 0, 0, 900));
		send_tick(make_tick(1'b1, 1000, 990, 900));
		send_tick(make_tick(1'b1, 1000, 989, 900));
		send_tick(make_tick(1'b1, 1000, 994, 900));
		send_tick(make_tick(1'b1, 1000, 995, 900));
		send_tick(make_tick(1'b1, 174, 992, 900));
		send_tick(make_tick(1'b1, 2047, 0, 899));
		send_tick(make_tick(1'b0, 0, 0, 0));
		send_tick(make_tick(1'b1, 0, 2047, 0));
		drain_results();
		// loss on the first missed tick, deadband low above high
		write_reg(REG_LOSS_LIMIT, 16'd0);
		write_reg(REG_DEADBAND_LOW, 16'd1500);
		write_reg(REG_DEADBAND_HIGH, 16'd500);
		send_tick(make_tick(1'b1, 1000, 1000, 2047));
		send_tick(make_tick(1'b1, 1000, 400, 2047));
		send_tick(make_tick(1'b0, 0, 0, 0));
		send_tick(make_tick(1'b0, 0, 0, 0));
		send_tick(make_tick(1'b1, 1000, 700, 2047));
		drain_results();
		write_reg(REG_LOSS_LIMIT, 16'd100);
		write_reg(REG_DEADBAND_LOW, 16'd990);
		write_reg(REG_DEADBAND_HIGH, 16'd994);
	endtask

	// a full ramp-up with random frames, then a short disarmed stretch
	task automatic test_ramp_up_random();
		load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom_range(1, CH_MAX)),
			16'($urandom_range(200, 65535)));
		run_stretch(1000, ARM_UP, 10);
		run_stretch(60, ARM_DOWN, 10);
		drain_results();
	endtask

	// register settings from the extremes to random, with short arm episodes
	task automatic test_register_sweep();
		int                left;
		int                len;
		logic [DATA_W-1:0] dl;
		logic [DATA_W-1:0] dh;
		for (int s = 0; s < 6; s++) begin
			case (s)
				0: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
				1: load_settings('1, '1, '1, '1, '1, '1, '1, '1);
				2: load_settings(16'd174, 16'hFFFF, 16'd992, 16'hFFFF, 16'd990, 16'd994,
					16'd900, 16'd100);
				3: begin
					dh = 16'($urandom_range(0, 1000));
					dl = 16'($urandom_range(1100, CH_MAX));
					load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						dl, dh, 16'($urandom_range(1, CH_MAX)), 16'($urandom_range(0, 8)));
				end
				default: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 40)));
			endcase
			left = 80;
			while (left > 0) begin
				len = $urandom_range(3, 40);
				if (len > left) len = left;
				case ($urandom_range(0, 2))
					0: run_stretch(len, ARM_UP, $urandom_range(0, 30));
					1: run_stretch(len, ARM_DOWN, $urandom_range(0, 30));
					default: run_stretch(len, ARM_ANY, $urandom_range(0, 30));
				endcase
				left = left - len;
			end
			drain_results();
		end
	endtask

	// receiver holds off long enough for the block to back up its input
	task automatic test_output_stall();
		send_gaps  = 1'b0;
		hold_token = hold_token + 1;
		run_stretch(40, ARM_ANY, 20);
		drain_results();
		send_gaps = 1'b1;
	endtask

	// arm, ramp up through frame-less ticks until the link is lost, ramp
	// down on the lost link, then a fresh frame arms again
	task automatic test_link_loss_run();
		send_gaps  = 1'b0;
		drain_gaps = 1'b0;
		write_reg(REG_ARM_THRESHOLD, 16'd1000);
		write_reg(REG_LOSS_LIMIT, 16'd150);
		send_tick(make_tick(1'b1, 1800, 1500, 1500));
		run_stretch(MISS_RUN, ARM_ANY, 100);
		send_tick(make_tick(1'b1, 1800, 300, 1500));
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// ready with random stall bursts, plus the long hold on request
	initial begin : drain_side
		int gap_left;
		int hold_left;
		int hold_seen;
		gap_left  = 0;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if (drain_gaps && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 14) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin : result_check
		drive_word_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (pending_drives.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("word %0d unexpected: left %0d right %0d armed %b lost %b",
						words_seen, left_drive, right_drive, is_armed, link_lost);
			end else begin
				want = pending_drives.pop_front();
				if (want.left !== left_drive || want.right !== right_drive ||
						want.armed !== is_armed || want.lost !== link_lost) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("word %0d: expected left %0d right %0d armed %b lost %b, %s",
							words_seen, want.left, want.right, want.armed, want.lost,
							$sformatf("got left %0d right %0d armed %b lost %b",
								left_drive, right_drive, is_armed, link_lost));
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("rc_mix_arm_ramp_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		frame_valid      = 1'b0;
		throttle_ch      = '0;
		turn_channel     = '0;
		arm_channel      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_ramp_up_random();
		test_register_sweep();
		test_output_stall();
		test_link_loss_run();

		// let any stray word show up
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("rc_mix_arm_ramp_unit regression: pass");
		else
			$display("rc_mix_arm_ramp_unit regression: fail");
		$finish;
	end

endmodule

// ----- rc_mix_arm_ramp_unit.f -----
src/rcm_pkg.sv
src/rcm_ser_mul.sv
src/rc_mix_arm_ramp_unit.sv
src/rcm_checker.sv
sim/rc_mix_arm_ramp_unit_test.sv
